>>> src/q7mlp_pkg.sv
package q7mlp_pkg;

    // default width of the hidden layer
    localparam int HIDDEN_COUNT_DEF = 8;

    // hidden sums stay within 17 bits, the output sum within 19 bits
    localparam int HID_W = 17;
    localparam int ACC_W = 19;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HIDDEN_WEIGHTS_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIDDEN_WEIGHTS_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIDDEN_BIASES    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_WEIGHTS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_BIAS      = 3'd4;

    localparam int PROB_W = 16;
    localparam logic [PROB_W-1:0] PROB_HALF = 16'd32768;

    // item moving down the chain of cells
    typedef struct packed {
        logic                    valid;
        logic signed [7:0]       a;
        logic signed [7:0]       b;
        logic signed [ACC_W-1:0] acc;
    } q7mlp_flow_t;

    // floor shift right by 7, then clamp to [-128, 127]
    function automatic logic signed [7:0] sat_shift7(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-8:0] s;
        logic signed [7:0]       r;
        s = x[ACC_W-1:7];
        if (!s[ACC_W-8] && (|s[ACC_W-9:7]))
            r = 8'sh7f;
        else if (s[ACC_W-8] && !(&s[ACC_W-9:7]))
            r = 8'sh80;
        else
            r = s[7:0];
        return r;
    endfunction

    // restoring long division, only used while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // (a*b) >> 60 for a, b below 2^61, truncated
    function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] xh;
        logic [63:0] xl;
        logic [63:0] yh;
        logic [63:0] yl;
        logic [63:0] r;
        xh = x >> 32;
        xl = {32'd0, x[31:0]};
        yh = y >> 32;
        yl = {32'd0, y[31:0]};
        r  = (xh * yh) << 4;
        r  = r + (((xh * yl) + (xl * yh)) >> 28);
        r  = r + ((xl * yl) >> 60);
        return r;
    endfunction

    // sigmoid(4*q/127) in unsigned q0.16, entry q+128, exact integer build
    function automatic logic [256*PROB_W-1:0] build_sig_table();
        logic [63:0] pw [0:128];
        logic [63:0] one_q60;
        logic [63:0] base;
        logic [63:0] term;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] v;
        logic [256*PROB_W-1:0] tbl;
        int          q;
        int          mag;
        one_q60 = 64'd1 << 60;
        base    = one_q60;
        term    = one_q60;
        tbl     = '0;
        // exp(-4/127) by alternating taylor series
        for (int k = 1; k < 24; k++)
        begin
            term = udiv64(term * 64'd4, 64'd127 * 64'(k));
            if (k % 2 == 1)
                base = base - term;
            else
                base = base + term;
        end
        pw[0] = one_q60;
        for (int i = 1; i <= 128; i++)
            pw[i] = mul_q60(pw[i-1], base);
        for (int i = 0; i < 256; i++)
        begin
            q   = i - 128;
            mag = (q < 0) ? -q : q;
            t   = pw[mag];
            d   = (one_q60 + t) >> 20;
            num = (q >= 0) ? (64'd1 << 56) : ((t >> 20) << 16);
            v   = udiv64(num + (d >> 1), d);
            if (v > 64'd65535)
                v = 64'd65535;
            tbl[i*PROB_W +: PROB_W] = v[PROB_W-1:0];
        end
        return tbl;
    endfunction

    localparam logic [256*PROB_W-1:0] SIG_TABLE = build_sig_table();

endpackage

>>> src/q7mlp_cell.sv
module q7mlp_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [7:0]      weight_a,
    input  logic signed [7:0]      weight_b,
    input  logic signed [7:0]      bias,
    input  logic signed [7:0]      weight_out,
    input  q7mlp_pkg::q7mlp_flow_t flow_in,
    output q7mlp_pkg::q7mlp_flow_t flow_out
);
    import q7mlp_pkg::*;

    logic signed [15:0]      prod_a;
    logic signed [15:0]      prod_b;
    logic signed [14:0]      bias_sh;
    logic signed [HID_W-1:0] hsum;
    logic signed [7:0]       hsat;
    logic [6:0]              hidden_next;

    logic                    mid_valid_reg;
    logic signed [7:0]       mid_a_reg;
    logic signed [7:0]       mid_b_reg;
    logic signed [ACC_W-1:0] mid_acc_reg;
    logic [6:0]              hidden_reg;

    logic signed [15:0]      prod_o;
    logic signed [ACC_W-1:0] acc_next;

    logic                    out_valid_reg;
    logic signed [7:0]       out_a_reg;
    logic signed [7:0]       out_b_reg;
    logic signed [ACC_W-1:0] out_acc_reg;

    // first half: hidden unit with relu
    always_comb
    begin
        prod_a      = 16'(flow_in.a) * 16'(weight_a);
        prod_b      = 16'(flow_in.b) * 16'(weight_b);
        bias_sh     = {bias, 7'd0};
        hsum        = HID_W'(prod_a) + HID_W'(prod_b) + HID_W'(bias_sh);
        hsat        = sat_shift7(ACC_W'(hsum));
        hidden_next = hsat[7] ? 7'd0 : hsat[6:0];
    end

    // second half: weighted hidden value into the running sum
    always_comb
    begin
        prod_o   = 16'($signed({1'b0, hidden_reg})) * 16'(weight_out);
        acc_next = mid_acc_reg + ACC_W'(prod_o);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= flow_in.valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_a_reg   <= flow_in.a;
        mid_b_reg   <= flow_in.b;
        mid_acc_reg <= flow_in.acc;
        hidden_reg  <= hidden_next;
        out_a_reg   <= mid_a_reg;
        out_b_reg   <= mid_b_reg;
        out_acc_reg <= acc_next;
    end

    always_comb
    begin
        flow_out.valid = out_valid_reg;
        flow_out.a     = out_a_reg;
        flow_out.b     = out_b_reg;
        flow_out.acc   = out_acc_reg;
    end

endmodule

>>> src/q7mlp_out_stage.sv
module q7mlp_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [7:0]              output_bias,
    input  q7mlp_pkg::q7mlp_flow_t         flow_in,
    output logic                           done,
    output logic signed [7:0]              pre_activation,
    output logic [q7mlp_pkg::PROB_W-1:0]   probability,
    output logic                           class_bit
);
    import q7mlp_pkg::*;

    logic signed [14:0]      bias_sh;
    logic signed [ACC_W-1:0] sum;
    logic signed [7:0]       q_next;

    logic                    q_valid_reg;
    logic signed [7:0]       q_reg;

    logic [7:0]              tbl_index;
    logic [PROB_W-1:0]       prob_next;

    logic                    done_reg;
    logic signed [7:0]       pre_reg;
    logic [PROB_W-1:0]       prob_reg;
    logic                    class_reg;

    always_comb
    begin
        bias_sh = {output_bias, 7'd0};
        sum     = flow_in.acc + ACC_W'(bias_sh);
        q_next  = sat_shift7(sum);
    end

    // table entry q+128: flip the sign bit
    always_comb
    begin
        tbl_index = {~q_reg[7], q_reg[6:0]};
        prob_next = SIG_TABLE[tbl_index*PROB_W +: PROB_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            q_valid_reg <= flow_in.valid;
            done_reg    <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        pre_reg   <= q_reg;
        prob_reg  <= prob_next;
        class_reg <= (prob_next > PROB_HALF);
    end

    assign done           = done_reg;
    assign pre_activation = pre_reg;
    assign probability    = prob_reg;
    assign class_bit      = class_reg;

endmodule

>>> src/q7_mlp_two_layer_inference_unit.sv
// int8 two-input perceptron with one hidden layer and a sigmoid output
// from start to done an item passes the mid and out registers of each hidden cell, then q_reg and the result registers
// throughput: one item per cycle while busy is low, set by the cell chain where each cell holds one hidden unit
// results appear on done for one cycle; the receiver cannot stall them
// reset: rst_n is asynchronous, active low; clears the configuration registers and the pipeline valid bits
// busy is high only while in reset and on the first clock after it
module q7_mlp_two_layer_inference_unit #(
    parameter int HIDDEN_COUNT = q7mlp_pkg::HIDDEN_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [7:0]                   input_a,
    input  logic signed [7:0]                   input_b,
    input  logic                                cfg_write,
    input  logic [q7mlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [q7mlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                done,
    output logic signed [7:0]                   pre_activation,
    output logic [q7mlp_pkg::PROB_W-1:0]        probability,
    output logic                                class_bit
);
    import q7mlp_pkg::*;

    // configuration registers; the 64-bit words pack one byte per hidden unit
    logic [63:0]       hidden_weights_from_a_reg;
    logic [63:0]       hidden_weights_from_b_reg;
    logic [63:0]       hidden_biases_reg;
    logic [63:0]       output_weights_reg;
    logic signed [7:0] output_bias_reg;

    // set in reset and cleared on every clock out of it; the chain takes an item every cycle while it is low
    logic busy_reg;

    // chain[0] is the item entering; chain[h+1] leaves hidden cell h
    q7mlp_flow_t chain [0:HIDDEN_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidden_weights_from_a_reg <= '0;
            hidden_weights_from_b_reg <= '0;
            hidden_biases_reg         <= '0;
            output_weights_reg        <= '0;
            output_bias_reg           <= '0;
            busy_reg                  <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_write)
            begin
                // indexes past the last register are dropped
                unique case (cfg_index)
                    REG_HIDDEN_WEIGHTS_A: hidden_weights_from_a_reg <= cfg_data;
                    REG_HIDDEN_WEIGHTS_B: hidden_weights_from_b_reg <= cfg_data;
                    REG_HIDDEN_BIASES:    hidden_biases_reg         <= cfg_data;
                    REG_OUTPUT_WEIGHTS:   output_weights_reg        <= cfg_data;
                    REG_OUTPUT_BIAS:      output_bias_reg           <= cfg_data[7:0];
                    default:              ;
                endcase
            end
        end
    end

    assign busy = busy_reg;

    // new item enters the chain with an empty output sum
    always_comb
    begin
        chain[0].valid = start && !busy_reg;
        chain[0].a     = input_a;
        chain[0].b     = input_b;
        chain[0].acc   = '0;
    end

    // one cell per hidden unit; each adds its weighted relu value to the sum
    for (genvar h = 0; h < HIDDEN_COUNT; h++)
    begin : g_cell
        q7mlp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .weight_a   (hidden_weights_from_a_reg[8*h +: 8]),
            .weight_b   (hidden_weights_from_b_reg[8*h +: 8]),
            .bias       (hidden_biases_reg[8*h +: 8]),
            .weight_out (output_weights_reg[8*h +: 8]),
            .flow_in    (chain[h]),
            .flow_out   (chain[h+1])
        );
    end

    // output bias, saturation and sigmoid lookup
    q7mlp_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .output_bias    (output_bias_reg),
        .flow_in        (chain[HIDDEN_COUNT]),
        .done           (done),
        .pre_activation (pre_activation),
        .probability    (probability),
        .class_bit      (class_bit)
    );

endmodule

>>> src/q7mlp_checker.sv
module q7mlp_checker #(
    parameter int HIDDEN_COUNT = q7mlp_pkg::HIDDEN_COUNT_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [7:0]            pre_activation,
    input logic [q7mlp_pkg::PROB_W-1:0] probability,
    input logic                         class_bit
);
    import q7mlp_pkg::*;

    localparam int LATENCY = 2 * HIDDEN_COUNT + 2;

    // every accepted item comes out on done
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not complete on time");

    // no result without a matching accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without accepted item");

    // class bit follows the probability
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (class_bit == (probability > PROB_HALF)))
        else $error("class bit does not match probability");

    // zero pre-activation maps to one half
    a_zero_half: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pre_activation == 8'sd0) |-> (probability == PROB_HALF))
        else $error("sigmoid of zero is not one half");

endmodule

bind q7_mlp_two_layer_inference_unit q7mlp_checker #(
    .HIDDEN_COUNT (HIDDEN_COUNT)
) u_q7mlp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .pre_activation (pre_activation),
    .probability    (probability),
    .class_bit      (class_bit)
);

>>> tb/q7_mlp_inference_checker.sv
module q7_mlp_inference_checker #(
    parameter int HIDDEN_COUNT = q7mlp_pkg::HIDDEN_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [7:0]                   input_a,
    input  logic signed [7:0]                   input_b,
    input  logic                                cfg_write,
    input  logic [q7mlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [q7mlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                done,
    input  logic signed [7:0]                   pre_activation,
    input  logic [q7mlp_pkg::PROB_W-1:0]        probability,
    input  logic                                class_bit,
    output int                                  error_count,
    output int                                  pending
);
    import q7mlp_pkg::*;

    typedef struct packed {
        logic signed [7:0]   pre_activation;
        logic [PROB_W-1:0]   probability;
        logic                class_bit;
    } mlp_answer_t;

    logic [63:0]       weights_a;
    logic [63:0]       weights_b;
    logic [63:0]       hidden_bias;
    logic [63:0]       weights_out;
    logic signed [7:0] bias_out;

    bit [PROB_W-1:0]   sigmoid_q16 [0:255];
    mlp_answer_t       predicted_answers [$];

    // sigmoid(4q/127) in q0.16, from exp(-4/127) powers in q60
    initial
    begin
        bit [63:0] powers [0:128];
        bit [63:0] one_q60;
        bit [63:0] base;
        bit [63:0] term;
        bit [63:0] xh;
        bit [63:0] xl;
        bit [63:0] yh;
        bit [63:0] yl;
        bit [63:0] prod;
        bit [63:0] t;
        bit [63:0] den;
        bit [63:0] num;
        bit [63:0] v;
        int        q;
        one_q60 = 64'd1 << 60;
        base    = one_q60;
        term    = one_q60;
        for (int k = 1; k < 24; k++)
        begin
            term = (term * 64'd4) / (64'd127 * 64'(k));
            if (k % 2 == 1)
                base = base - term;
            else
                base = base + term;
        end
        powers[0] = one_q60;
        yh = base >> 32;
        yl = base & 64'hFFFF_FFFF;
        for (int i = 1; i <= 128; i++)
        begin
            xh   = powers[i-1] >> 32;
            xl   = powers[i-1] & 64'hFFFF_FFFF;
            prod = (xh * yh) << 4;
            prod = prod + (((xh * yl) + (xl * yh)) >> 28);
            prod = prod + ((xl * yl) >> 60);
            powers[i] = prod;
        end
        for (int i = 0; i < 256; i++)
        begin
            q   = i - 128;
            t   = powers[(q < 0) ? -q : q];
            den = (one_q60 + t) >> 20;
            num = (q >= 0) ? (64'd1 << 56) : ((t >> 20) << 16);
            v   = (num + den / 64'd2) / den;
            if (v > 64'd65535)
                v = 64'd65535;
            sigmoid_q16[i] = v[PROB_W-1:0];
        end
    end

    // floor shift by 7 then clamp to q7
    function automatic int clamp_shift7(input int acc);
        int r;
        r = acc >>> 7;
        if (r > 127)
            r = 127;
        if (r < -128)
            r = -128;
        return r;
    endfunction

    function automatic mlp_answer_t infer_mlp(input logic signed [7:0] a,
                                              input logic signed [7:0] b);
        mlp_answer_t       ans;
        logic signed [7:0] wa;
        logic signed [7:0] wb;
        logic signed [7:0] hb;
        logic signed [7:0] wo;
        int                hv;
        int                acc_out;
        int                q;
        acc_out = 0;
        for (int h = 0; h < HIDDEN_COUNT && h < 8; h++)
        begin
            wa = weights_a[8*h +: 8];
            wb = weights_b[8*h +: 8];
            hb = hidden_bias[8*h +: 8];
            wo = weights_out[8*h +: 8];
            hv = clamp_shift7(int'(a) * int'(wa) + int'(b) * int'(wb) + int'(hb) * 128);
            if (hv < 0)
                hv = 0;
            acc_out += hv * int'(wo);
        end
        q = clamp_shift7(acc_out + int'(bias_out) * 128);
        ans.pre_activation = 8'(q);
        ans.probability    = sigmoid_q16[q + 128];
        ans.class_bit      = (ans.probability > PROB_HALF);
        return ans;
    endfunction

    always @(posedge clk)
    begin
        mlp_answer_t exp_ans;
        if (!rst_n)
        begin
            // registers come out of reset at zero
            weights_a   = '0;
            weights_b   = '0;
            hidden_bias = '0;
            weights_out = '0;
            bias_out    = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_HIDDEN_WEIGHTS_A: weights_a   = cfg_data;
                    REG_HIDDEN_WEIGHTS_B: weights_b   = cfg_data;
                    REG_HIDDEN_BIASES:    hidden_bias = cfg_data;
                    REG_OUTPUT_WEIGHTS:   weights_out = cfg_data;
                    REG_OUTPUT_BIAS:      bias_out    = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predicted_answers.push_back(infer_mlp(input_a, input_b));
            if (done)
            begin
                if (predicted_answers.size() == 0)
                begin
                    $error("result with no item outstanding");
                    error_count++;
                end
                else
                begin
                    exp_ans = predicted_answers.pop_front();
                    if (pre_activation !== exp_ans.pre_activation)
                    begin
                        $error("pre_activation: expected %0d, actual %0d",
                               exp_ans.pre_activation, pre_activation);
                        error_count++;
                    end
                    if (probability !== exp_ans.probability)
                    begin
                        $error("probability: expected %0d, actual %0d",
                               exp_ans.probability, probability);
                        error_count++;
                    end
                    if (class_bit !== exp_ans.class_bit)
                    begin
                        $error("class_bit: expected %0d, actual %0d",
                               exp_ans.class_bit, class_bit);
                        error_count++;
                    end
                end
            end
        end
        pending <= predicted_answers.size();
    end

endmodule

>>> tb/q7_mlp_two_layer_inference_unit_tb.sv
module q7_mlp_two_layer_inference_unit_tb;
    import q7mlp_pkg::*;

    localparam int HIDDEN_UNITS = HIDDEN_COUNT_DEF;
    // clocks from start to done through the cell chain and the output stage
    localparam int LATENCY = 2 * HIDDEN_UNITS + 2;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 48;
    // first index past the register map, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_OUTPUT_BIAS + 1'b1;

    // how the bytes of a packed weight register get filled
    typedef enum int {
        FILL_ZERO,
        FILL_MAX,
        FILL_MIN,
        FILL_FULL,
        FILL_SMALL
    } fill_style_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [7:0]         input_a;
    logic signed [7:0]         input_b;
    logic                      cfg_write;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      done;
    logic signed [7:0]         pre_activation;
    logic [PROB_W-1:0]         probability;
    logic                      class_bit;

    int                        fail_count;
    int                        outstanding;
    bit                        sender_idles;

    q7_mlp_two_layer_inference_unit #(
        .HIDDEN_COUNT(HIDDEN_UNITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .input_a        (input_a),
        .input_b        (input_b),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pre_activation (pre_activation),
        .probability    (probability),
        .class_bit      (class_bit)
    );

    // watches both channels and the register port, predicts and compares
    q7_mlp_inference_checker #(
        .HIDDEN_COUNT(HIDDEN_UNITS)
    ) inference_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .input_a        (input_a),
        .input_b        (input_b),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pre_activation (pre_activation),
        .probability    (probability),
        .class_bit      (class_bit),
        .error_count    (fail_count),
        .pending        (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("[q7_mlp_two_layer_inference_unit] ERROR");
        $finish;
    end

    function automatic logic [63:0] pack_bytes(input fill_style_t style);
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
        begin
            case (style)
                FILL_ZERO:  v[8*i +: 8] = 8'h00;
                FILL_MAX:   v[8*i +: 8] = 8'h7f;
                FILL_MIN:   v[8*i +: 8] = 8'h80;
                FILL_FULL:  v[8*i +: 8] = 8'($urandom);
                default:    v[8*i +: 8] = 8'(int'($urandom_range(24)) - 12);
            endcase
        end
        return v;
    endfunction

    // skewed toward full random and small magnitudes, extremes now and then
    function automatic fill_style_t pick_style();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return FILL_ZERO;
        else if (r == 1)
            return FILL_MAX;
        else if (r == 2)
            return FILL_MIN;
        else if (r <= 5)
            return FILL_FULL;
        else
            return FILL_SMALL;
    endfunction

    // q7 input, mostly uniform, sometimes a corner value
    function automatic logic signed [7:0] pick_q7();
        if ($urandom_range(9) != 0)
            return 8'($urandom);
        case ($urandom_range(4))
            0:       return -8'sd128;
            1:       return -8'sd1;
            2:       return 8'sd0;
            3:       return 8'sd1;
            default: return 8'sd127;
        endcase
    endfunction

    // one item: optional idle cycles, then hold start until accepted
    task automatic send_item(input logic signed [7:0] a, input logic signed [7:0] b);
        while (sender_idles && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        input_a <= a;
        input_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // drain: every expected result back, then let the pipe empty out
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // all five registers plus a stray write past the map; block must be idle
    task automatic program_net(input logic [63:0] wa, input logic [63:0] wb,
                               input logic [63:0] hb, input logic [63:0] wo,
                               input logic [7:0] ob);
        write_reg(REG_HIDDEN_WEIGHTS_A, wa);
        write_reg(REG_HIDDEN_WEIGHTS_B, wb);
        write_reg(REG_HIDDEN_BIASES, hb);
        write_reg(REG_OUTPUT_WEIGHTS, wo);
        write_reg(REG_OUTPUT_BIAS, {$urandom, 24'($urandom), ob});
        write_reg(REG_FIRST_UNUSED + CFG_INDEX_W'($urandom_range(2)),
                  {$urandom, $urandom});
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        start     <= 1'b0;
        input_a   <= '0;
        input_b   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        sender_idles = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: every answer is sigmoid(0)
        send_item(8'sd0, 8'sd0);
        send_item(8'sd127, -8'sd128);
        send_item(-8'sd128, 8'sd127);
        settle();

        // everything at +127; for inputs (127, 127) and (0, 0) the hidden units saturate high
        program_net(pack_bytes(FILL_MAX), pack_bytes(FILL_MAX), pack_bytes(FILL_MAX),
                    pack_bytes(FILL_MAX), 8'h7f);
        send_item(8'sd127, 8'sd127);
        send_item(-8'sd128, -8'sd128);
        send_item(-8'sd128, 8'sd127);
        send_item(8'sd0, 8'sd0);
        settle();

        // everything at -128, relu kills the hidden layer but for inputs (-128, -128)
        program_net(pack_bytes(FILL_MIN), pack_bytes(FILL_MIN), pack_bytes(FILL_MIN),
                    pack_bytes(FILL_MIN), 8'h80);
        send_item(8'sd127, 8'sd127);
        send_item(-8'sd128, -8'sd128);
        send_item(8'sd127, -8'sd128);
        send_item(8'sd1, -8'sd1);
        settle();

        // opposing extremes, output driven to either rail
        program_net(pack_bytes(FILL_MAX), pack_bytes(FILL_MIN), pack_bytes(FILL_ZERO),
                    pack_bytes(FILL_MAX), 8'h80);
        send_item(8'sd127, -8'sd128);
        send_item(-8'sd128, 8'sd127);
        send_item(8'sd64, 8'sd0);
        send_item(-8'sd1, -8'sd1);
        settle();

        // small weights keep q off the rails so the table gets walked
        program_net(pack_bytes(FILL_SMALL), pack_bytes(FILL_SMALL), pack_bytes(FILL_SMALL),
                    pack_bytes(FILL_SMALL), 8'h00);
        send_item(8'sd127, 8'sd127);
        send_item(-8'sd128, 8'sd127);
        send_item(8'sd127, -8'sd128);
        send_item(-8'sd128, -8'sd128);
        send_item(8'sd0, 8'sd0);
        settle();

        // random networks; phases 4 and 5 run back to back with no idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sender_idles = !(phase == 4 || phase == 5);
            program_net(pack_bytes(pick_style()), pack_bytes(pick_style()),
                        pack_bytes(pick_style()), pack_bytes(pick_style()),
                        8'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(pick_q7(), pick_q7());
            settle();
        end

        if (fail_count == 0)
            $display("[q7_mlp_two_layer_inference_unit] OK");
        else
            $display("[q7_mlp_two_layer_inference_unit] ERROR");
        $finish;
    end

endmodule
